[hdl/idd_pkg.sv]
// Shared types and constants of the intermittent drop detector.
package idd_pkg;

   // Configuration register indexes
   localparam logic [7:0] CSR_DROP_THRESHOLD     = 8'd0;
   localparam logic [7:0] CSR_AUTOCORR_THRESHOLD = 8'd1;
   localparam logic [7:0] CSR_MIN_LAG            = 8'd2;
   localparam logic [7:0] CSR_MAX_LAG            = 8'd3;

   // Register reset values
   localparam logic [15:0] DROP_THRESHOLD_RESET     = 16'd16384;
   localparam logic [15:0] AUTOCORR_THRESHOLD_RESET = 16'd128;
   localparam logic [5:0]  MIN_LAG_RESET            = 6'd1;
   localparam logic [5:0]  MAX_LAG_RESET            = 6'd8;

   // Decision causes
   localparam logic [2:0] CAUSE_TOO_SHORT   = 3'd0;
   localparam logic [2:0] CAUSE_FEW_DROPS   = 3'd1;
   localparam logic [2:0] CAUSE_NO_RECOVERY = 3'd2;
   localparam logic [2:0] CAUSE_EPISODES    = 3'd3;
   localparam logic [2:0] CAUSE_PERIODIC    = 3'd4;
   localparam logic [2:0] CAUSE_NONE        = 3'd5;

   // Autocorrelation gamma is Q8.8, so the sum side is scaled by 256
   localparam int GAMMA_FRAC_BITS = 8;

   typedef struct packed {
      logic [15:0] pdr_sample;
      logic        last_sample;
   } req_word_type;

   typedef struct packed {
      logic       intermittent_detected;
      logic [2:0] decision_cause;
      logic       window_overflow;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LAG,
      ST_SUM,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4
   } state_type;

endpackage

[hdl/idd_ram.sv]
// Generic RAM: one write port, two registered read ports.
module idd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

[hdl/idd_mul.sv]
// Shared unsigned multiplier with a registered product.
module idd_mul #(
   parameter int A_WIDTH = 23,
   parameter int B_WIDTH = 7
) (
   input  logic                       clock,
   input  logic [A_WIDTH-1:0]         op_a,
   input  logic [B_WIDTH-1:0]         op_b,
   output logic [A_WIDTH+B_WIDTH-1:0] product_ff
);

   logic [A_WIDTH+B_WIDTH-1:0] product_in;

   assign product_in = (A_WIDTH + B_WIDTH)'(op_a) * (A_WIDTH + B_WIDTH)'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

[hdl/intermittent_drop_detector_core.sv]
// Top level of the intermittent drop detector: sample intake, sequencer, decision.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+--------------------------
//   request | start, busy, req_word                   | taken when start & !busy
//   result  | rsp_valid, rsp_word                     | one-cycle strobe, no stall
//   config  | csr_valid, csr_ready, csr_index, csr_wdata | taken when valid & ready
//
// A sample that is not the last of its window is taken in ST_IDLE; busy stays low.
// The last sample starts the decision: a check state, then for each lag L tried
// a setup state, pair reads of t = L to W-1 from the two-port drop-bit RAM and
// the states ST_MUL1 to ST_MUL4 on the shared multiplier. The result strobe comes at
// the end and busy drops with it.
// Reset is synchronous, active high; it restores the configuration registers and clears the window.
// The drop-bit RAM is not cleared: only entries of the current window are read.
module intermittent_drop_detector_core
   import idd_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int NW = (CW > 7) ? CW : 7;
   localparam int MA = 16 + CW;
   localparam int PW = MA + CW;

   // Configuration registers
   logic [15:0] drop_threshold_ff;
   logic [15:0] autocorr_threshold_ff;
   logic [5:0]  min_lag_ff;
   logic [5:0]  max_lag_ff;

   // Window state
   logic [CW-1:0] sample_count_ff, sample_count_in;
   logic [CW-1:0] drop_count_ff, drop_count_in;
   logic [1:0]    episode_count_ff, episode_count_in;
   logic          previous_drop_ff, previous_drop_in;
   logic          overflow_seen_ff, overflow_seen_in;

   // Sequencer state
   state_type     state_ff, state_in;
   logic [6:0]    lag_ff, lag_in;
   logic [CW-1:0] t_ff, t_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [PW-1:0] rhs_ff, rhs_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // RAM and multiplier hookups
   logic          wr_en;
   logic          drop_bit;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic          rd_data_a, rd_data_b;
   logic [MA-1:0] mul_a;
   logic [CW-1:0] mul_b;
   logic [PW-1:0] product_ff;
   logic [PW-1:0] lhs;

   logic          accept;
   logic          has_room;
   logic [NW-1:0] w_n, lag_n, t_n, min_lag_n, max_lag_n, drops_n;
   logic [CW-1:0] terms;

   assign accept    = start && !busy;
   assign has_room  = sample_count_ff < CW'(WINDOW_MAX);
   assign drop_bit  = req_word.pdr_sample < drop_threshold_ff;
   assign wr_en     = accept && has_room;
   assign w_n       = NW'(sample_count_ff);
   assign drops_n   = NW'(drop_count_ff);
   assign lag_n     = NW'(lag_ff);
   assign t_n       = NW'(t_ff);
   assign min_lag_n = NW'(min_lag_ff);
   assign max_lag_n = NW'(max_lag_ff);
   assign terms     = CW'(w_n - lag_n);
   assign rd_addr_a = t_ff[AW-1:0];
   assign rd_addr_b = AW'(t_n - lag_n);
   assign lhs       = product_ff << GAMMA_FRAC_BITS;

   idd_ram #(
      .WIDTH(1),
      .DEPTH(WINDOW_MAX)
   ) u_drop_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (sample_count_ff[AW-1:0]),
      .wr_data  (drop_bit),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   idd_mul #(
      .A_WIDTH(MA),
      .B_WIDTH(CW)
   ) u_mul (
      .clock     (clock),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .product_ff(product_ff)
   );

   // Configuration writes; only taken while idle by contract
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_threshold_ff     <= DROP_THRESHOLD_RESET;
         autocorr_threshold_ff <= AUTOCORR_THRESHOLD_RESET;
         min_lag_ff            <= MIN_LAG_RESET;
         max_lag_ff            <= MAX_LAG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DROP_THRESHOLD:     drop_threshold_ff     <= csr_wdata;
            CSR_AUTOCORR_THRESHOLD: autocorr_threshold_ff <= csr_wdata;
            CSR_MIN_LAG:            min_lag_ff            <= csr_wdata[5:0];
            CSR_MAX_LAG:            max_lag_ff            <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         sample_count_ff  <= '0;
         drop_count_ff    <= '0;
         episode_count_ff <= '0;
         previous_drop_ff <= 1'b0;
         overflow_seen_ff <= 1'b0;
         rd_vld_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sample_count_ff  <= sample_count_in;
         drop_count_ff    <= drop_count_in;
         episode_count_ff <= episode_count_in;
         previous_drop_ff <= previous_drop_in;
         overflow_seen_ff <= overflow_seen_in;
         rd_vld_ff        <= rd_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      lag_ff      <= lag_in;
      t_ff        <= t_in;
      sum_ff      <= sum_in;
      rhs_ff      <= rhs_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Next state, sample intake and lag sweep
   always_comb begin
      state_in         = state_ff;
      sample_count_in  = sample_count_ff;
      drop_count_in    = drop_count_ff;
      episode_count_in = episode_count_ff;
      previous_drop_in = previous_drop_ff;
      overflow_seen_in = overflow_seen_ff;
      lag_in           = lag_ff;
      t_in             = t_ff;
      sum_in           = sum_ff + CW'(rd_vld_ff & rd_data_a & rd_data_b);
      rd_vld_in        = 1'b0;
      rhs_in           = rhs_ff;
      rsp_valid_in     = 1'b0;
      rsp_word_in      = rsp_word_ff;
      mul_a            = MA'(autocorr_threshold_ff);
      mul_b            = terms;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  sample_count_in  = sample_count_ff + 1'b1;
                  drop_count_in    = drop_count_ff + CW'(drop_bit);
                  previous_drop_in = drop_bit;
                  if (drop_bit && !previous_drop_ff && episode_count_ff != 2'd2) begin
                     episode_count_in = episode_count_ff + 1'b1;
                  end
               end else begin
                  overflow_seen_in = 1'b1;
               end
               if (req_word.last_sample) begin
                  state_in = ST_CHECK;
               end
            end
         end
         // Early-out tests on the window counters
         ST_CHECK: begin
            lag_in = {1'b0, min_lag_ff};
            rsp_word_in.decision_cause = CAUSE_NONE;
            if (w_n < min_lag_n + 1'b1) begin
               rsp_word_in.decision_cause = CAUSE_TOO_SHORT;
            end else if (drops_n < NW'(2)) begin
               rsp_word_in.decision_cause = CAUSE_FEW_DROPS;
            end else if (w_n == drops_n) begin
               rsp_word_in.decision_cause = CAUSE_NO_RECOVERY;
            end else if (episode_count_ff == 2'd2) begin
               rsp_word_in.decision_cause = CAUSE_EPISODES;
            end
            if (rsp_word_in.decision_cause == CAUSE_NONE) begin
               state_in = ST_LAG;
            end else begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         // Start one lag or finish the sweep
         ST_LAG: begin
            sum_in = '0;
            t_in   = CW'(lag_n);
            if (lag_n > max_lag_n || lag_n >= w_n) begin
               rsp_word_in.decision_cause = CAUSE_NONE;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SUM;
            end
         end
         // Pair reads m[t] and m[t-lag]; data lands in the next cycle
         ST_SUM: begin
            if (t_n < w_n) begin
               rd_vld_in = 1'b1;
               t_in = t_ff + 1'b1;
            end else begin
               state_in = ST_MUL1;
            end
         end
         // gamma * terms
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         // (gamma * terms) * drops
         ST_MUL2: begin
            mul_a = product_ff[MA-1:0];
            mul_b = drop_count_ff;
            state_in = ST_MUL3;
         end
         // sum * W
         ST_MUL3: begin
            rhs_in = product_ff;
            mul_a = MA'(sum_ff);
            mul_b = sample_count_ff;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            if (lhs > rhs_ff) begin
               rsp_word_in.decision_cause = CAUSE_PERIODIC;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               lag_in = lag_ff + 1'b1;
               state_in = ST_LAG;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Report and clear the window together
      if (rsp_valid_in) begin
         rsp_word_in.intermittent_detected =
            (rsp_word_in.decision_cause == CAUSE_EPISODES) ||
            (rsp_word_in.decision_cause == CAUSE_PERIODIC);
         rsp_word_in.window_overflow = overflow_seen_ff;
         sample_count_in  = '0;
         drop_count_in    = '0;
         episode_count_in = '0;
         previous_drop_in = 1'b0;
         overflow_seen_in = 1'b0;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held over two cycles");

   a_detect_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.intermittent_detected |->
         (rsp_word.decision_cause == CAUSE_EPISODES ||
          rsp_word.decision_cause == CAUSE_PERIODIC))
      else $error("detection flag disagrees with cause");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff <= CW'(WINDOW_MAX) && drop_count_ff <= sample_count_ff)
      else $error("window counters out of range");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a decision pass");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL1 |-> sum_ff <= terms)
      else $error("pair sum exceeds term count");

endmodule
